// ----- sv/m1et_pkg.sv -----
`default_nettype none
package m1et_pkg;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam int RATIO_STAGES = 34;
  localparam int DIV1_STEPS   = 31;
  localparam int SQRT_STAGES  = 32;
  localparam int CHI_STEPS    = 32;

  localparam logic [31:0] Q30_THIRD = 32'd357913941;
  localparam logic [29:0] Q30_HALF  = 30'd536870912;
  localparam logic [29:0] CHI_MIN   = 30'd178956971;

  typedef struct packed {
    logic [1:0]         row_index;
    logic [1:0]         col_index;
    logic [31:0]        energy_density;
    logic signed [31:0] flux_x;
    logic signed [31:0] flux_y;
    logic signed [31:0] flux_z;
  } in_t;

  typedef struct packed {
    logic diag;
    logic neg;
    logic zero;
    logic free;
  } flags_t;

  typedef struct packed {
    flags_t      flags;
    logic [63:0] pij;
    logic [63:0] f2;
    logic [63:0] u2;
  } front_t;

  typedef struct packed {
    flags_t      flags;
    logic [31:0] q1;
    logic [33:0] q2;
  } ratio_t;

  typedef struct packed {
    flags_t      flags;
    logic [31:0] nn;
    logic [35:0] num;
    logic [31:0] sq;
  } sqrt_t;

  function automatic logic [31:0] mag(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

endpackage
`default_nettype wire

// ----- sv/m1et_ifs.sv -----
`default_nettype none
interface m1et_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         row_index;
  logic [1:0]         col_index;
  logic [31:0]        energy_density;
  logic signed [31:0] flux_x;
  logic signed [31:0] flux_y;
  logic signed [31:0] flux_z;

  modport source (output valid, row_index, col_index, energy_density, flux_x, flux_y, flux_z,
                  input ready);
  modport sink (input valid, row_index, col_index, energy_density, flux_x, flux_y, flux_z,
                output ready);
endinterface

interface m1et_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] tensor_component;

  modport source (output valid, tensor_component, input ready);
  modport sink (input valid, tensor_component, output ready);
endinterface
`default_nettype wire

// ----- sv/m1et_front.sv -----
`default_nettype none
module m1et_front (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  en,
  input  wire                  valid_i,
  input  wire m1et_pkg::in_t   data_i,
  output logic                 valid_o,
  output m1et_pkg::front_t     data_o
);

  logic        mx_nxt, unused_nxt;
  logic [31:0] ax, ay, az, mi_nxt, mj_nxt;
  logic        si, sj;

  logic        v1_r, v2_r, v3_r, v4_r;
  logic [31:0] mx_r, my_r, mz_r, mi_r, mj_r, u_r;
  logic        diag1_r, neg1_r;
  logic [63:0] sqx_r, sqy_r, sqz_r, u2_2_r, pij2_r;
  logic        uz2_r, diag2_r, neg2_r;
  logic [63:0] f2_3_r, u2_3_r, pij3_r;
  logic        uz3_r, diag3_r, neg3_r;
  m1et_pkg::front_t d4_r;

  assign mx_nxt     = 1'b0;
  assign unused_nxt = mx_nxt;

  always_comb begin
    ax = m1et_pkg::mag(data_i.flux_x);
    ay = m1et_pkg::mag(data_i.flux_y);
    az = m1et_pkg::mag(data_i.flux_z);
    unique case (data_i.row_index)
      m1et_pkg::AXIS_X: begin mi_nxt = ax; si = data_i.flux_x[31]; end
      m1et_pkg::AXIS_Y: begin mi_nxt = ay; si = data_i.flux_y[31]; end
      m1et_pkg::AXIS_Z: begin mi_nxt = az; si = data_i.flux_z[31]; end
      default:          begin mi_nxt = 32'd0; si = unused_nxt; end
    endcase
    unique case (data_i.col_index)
      m1et_pkg::AXIS_X: begin mj_nxt = ax; sj = data_i.flux_x[31]; end
      m1et_pkg::AXIS_Y: begin mj_nxt = ay; sj = data_i.flux_y[31]; end
      m1et_pkg::AXIS_Z: begin mj_nxt = az; sj = data_i.flux_z[31]; end
      default:          begin mj_nxt = 32'd0; sj = 1'b0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= valid_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mx_r    <= ax;
      my_r    <= ay;
      mz_r    <= az;
      mi_r    <= mi_nxt;
      mj_r    <= mj_nxt;
      u_r     <= data_i.energy_density;
      diag1_r <= (data_i.row_index == data_i.col_index);
      neg1_r  <= si ^ sj;

      sqx_r   <= 64'(mx_r) * 64'(mx_r);
      sqy_r   <= 64'(my_r) * 64'(my_r);
      sqz_r   <= 64'(mz_r) * 64'(mz_r);
      u2_2_r  <= 64'(u_r) * 64'(u_r);
      pij2_r  <= 64'(mi_r) * 64'(mj_r);
      uz2_r   <= (u_r == 32'd0);
      diag2_r <= diag1_r;
      neg2_r  <= neg1_r;

      f2_3_r  <= sqx_r + sqy_r + sqz_r;
      u2_3_r  <= u2_2_r;
      pij3_r  <= pij2_r;
      uz3_r   <= uz2_r;
      diag3_r <= diag2_r;
      neg3_r  <= neg2_r;

      d4_r.flags.diag <= diag3_r;
      d4_r.flags.neg  <= neg3_r;
      d4_r.flags.zero <= (f2_3_r == 64'd0) || uz3_r;
      d4_r.flags.free <= (f2_3_r > u2_3_r);
      d4_r.pij        <= pij3_r;
      d4_r.f2         <= f2_3_r;
      d4_r.u2         <= u2_3_r;
    end
  end

  assign valid_o = v4_r;
  assign data_o  = d4_r;

endmodule
`default_nettype wire

// ----- sv/m1et_ratio.sv -----
`default_nettype none
module m1et_ratio (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   en,
  input  wire                   valid_i,
  input  wire m1et_pkg::front_t data_i,
  output logic                  valid_o,
  output m1et_pkg::ratio_t      data_o
);

  localparam int N = m1et_pkg::RATIO_STAGES;

  logic             v_r  [N];
  m1et_pkg::flags_t fl_r [N];
  logic [63:0]      r1_r [N];
  logic [63:0]      b1_r [N];
  logic [63:0]      r2_r [N];
  logic [63:0]      b2_r [N];
  logic [31:0]      q1_r [N];
  logic [33:0]      q2_r [N];

  for (genvar k = 0; k < N; k++) begin : g_st
    logic             v_nxt;
    m1et_pkg::flags_t fl_nxt;
    logic [63:0]      r1_nxt, b1_nxt, r2_nxt, b2_nxt;
    logic [31:0]      q1_nxt;
    logic [33:0]      q2_nxt;
    logic             ge1, ge2;

    if (k == 0) begin : g_init
      always_comb begin
        ge1    = data_i.pij >= data_i.f2;
        ge2    = data_i.f2 >= data_i.u2;
        v_nxt  = valid_i;
        fl_nxt = data_i.flags;
        b1_nxt = data_i.f2;
        b2_nxt = data_i.u2;
        r1_nxt = data_i.pij - (ge1 ? data_i.f2 : 64'd0);
        r2_nxt = data_i.f2 - (ge2 ? data_i.u2 : 64'd0);
        q1_nxt = {31'd0, ge1};
        q2_nxt = {33'd0, ge2};
      end
    end else begin : g_iter
      logic [64:0] t1, t2;
      always_comb begin
        t1     = {r1_r[k-1], 1'b0};
        t2     = {r2_r[k-1], 1'b0};
        ge1    = t1 >= {1'b0, b1_r[k-1]};
        ge2    = t2 >= {1'b0, b2_r[k-1]};
        v_nxt  = v_r[k-1];
        fl_nxt = fl_r[k-1];
        b1_nxt = b1_r[k-1];
        b2_nxt = b2_r[k-1];
        if (k <= m1et_pkg::DIV1_STEPS) begin
          r1_nxt = t1[63:0] - (ge1 ? b1_r[k-1] : 64'd0);
          q1_nxt = {q1_r[k-1][30:0], ge1};
        end else begin
          r1_nxt = r1_r[k-1];
          q1_nxt = q1_r[k-1];
        end
        r2_nxt = t2[63:0] - (ge2 ? b2_r[k-1] : 64'd0);
        q2_nxt = {q2_r[k-1][32:0], ge2};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_nxt;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        fl_r[k] <= fl_nxt;
        r1_r[k] <= r1_nxt;
        b1_r[k] <= b1_nxt;
        r2_r[k] <= r2_nxt;
        b2_r[k] <= b2_nxt;
        q1_r[k] <= q1_nxt;
        q2_r[k] <= q2_nxt;
      end
    end
  end

  assign valid_o      = v_r[N-1];
  assign data_o.flags = fl_r[N-1];
  assign data_o.q1    = q1_r[N-1];
  assign data_o.q2    = q2_r[N-1];

endmodule
`default_nettype wire

// ----- sv/m1et_sqrt.sv -----
`default_nettype none
module m1et_sqrt (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   en,
  input  wire                   valid_i,
  input  wire m1et_pkg::ratio_t data_i,
  output logic                  valid_o,
  output m1et_pkg::sqrt_t       data_o
);

  localparam int N = m1et_pkg::SQRT_STAGES;

  logic             v0_r, v1_r;
  m1et_pkg::flags_t fl0_r, fl1_r;
  logic [31:0]      nn0_r, nn1_r;
  logic [33:0]      f2q0_r;
  logic [35:0]      num1_r;
  logic [63:0]      x1_r;

  logic             v_r   [N];
  m1et_pkg::flags_t fl_r  [N];
  logic [31:0]      nn_r  [N];
  logic [35:0]      num_r [N];
  logic [63:0]      x_r   [N];
  logic [63:0]      res_r [N];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else if (en) begin
      v0_r <= valid_i;
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fl0_r  <= data_i.flags;
      nn0_r  <= 32'((33'(data_i.q1) + 33'd1) >> 1);
      f2q0_r <= 34'((35'(data_i.q2) + 35'd1) >> 1);

      fl1_r  <= fl0_r;
      nn1_r  <= nn0_r;
      num1_r <= (36'd3 << 31) + (36'(f2q0_r) << 1);
      x1_r   <= ((64'd1 << 34) - 64'(f2q0_r) * 64'd3) << 28;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_st
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic             v_nxt;
    m1et_pkg::flags_t fl_nxt;
    logic [31:0]      nn_nxt;
    logic [35:0]      num_nxt;
    logic [63:0]      x_in, res_in, t, x_nxt, res_nxt;

    if (k == 0) begin : g_head
      always_comb begin
        v_nxt   = v1_r;
        fl_nxt  = fl1_r;
        nn_nxt  = nn1_r;
        num_nxt = num1_r;
        x_in    = x1_r;
        res_in  = 64'd0;
      end
    end else begin : g_body
      always_comb begin
        v_nxt   = v_r[k-1];
        fl_nxt  = fl_r[k-1];
        nn_nxt  = nn_r[k-1];
        num_nxt = num_r[k-1];
        x_in    = x_r[k-1];
        res_in  = res_r[k-1];
      end
    end

    always_comb begin
      t = res_in + BIT;
      if (x_in >= t) begin
        x_nxt   = x_in - t;
        res_nxt = (res_in >> 1) + BIT;
      end else begin
        x_nxt   = x_in;
        res_nxt = res_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_nxt;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        fl_r[k]  <= fl_nxt;
        nn_r[k]  <= nn_nxt;
        num_r[k] <= num_nxt;
        x_r[k]   <= x_nxt;
        res_r[k] <= res_nxt;
      end
    end
  end

  assign valid_o      = v_r[N-1];
  assign data_o.flags = fl_r[N-1];
  assign data_o.nn    = nn_r[N-1];
  assign data_o.num   = num_r[N-1];
  assign data_o.sq    = res_r[N-1][31:0];

endmodule
`default_nettype wire

// ----- sv/m1et_chi.sv -----
`default_nettype none
module m1et_chi (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  en,
  input  wire                  valid_i,
  input  wire m1et_pkg::sqrt_t data_i,
  output logic                 valid_o,
  output logic signed [31:0]   result_o
);

  localparam int N = m1et_pkg::CHI_STEPS;

  logic             v0_r;
  m1et_pkg::flags_t fl0_r;
  logic [31:0]      nn0_r, lo0_r;
  logic [33:0]      den0_r, rem0_r;
  logic [63:0]      dvd;

  logic             v_r   [N];
  m1et_pkg::flags_t fl_r  [N];
  logic [31:0]      nn_r  [N];
  logic [31:0]      lo_r  [N];
  logic [33:0]      den_r [N];
  logic [33:0]      rem_r [N];
  logic [31:0]      q_r   [N];

  logic             vp1_r, vp2_r, vp3_r, vp4_r, vp5_r;
  m1et_pkg::flags_t flp1_r, flp2_r, flp3_r, flp4_r;
  logic [31:0]      nnp1_r, nnp2_r, nnp3_r;
  logic [29:0]      chi1_r, c1, chi_nxt;
  logic [30:0]      coef2_r;
  logic [29:0]      dsum2_r, dsum3_r, dsum4_r;
  logic [61:0]      prod3_r;
  logic [31:0]      p4_r, fv4_r;
  logic signed [31:0] res5_r, res_nxt, pm;

  assign dvd = (64'(data_i.num) << 28) + 64'(34'd5 << 29) + 64'(data_i.sq);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fl0_r  <= data_i.flags;
      nn0_r  <= data_i.nn;
      den0_r <= (34'd5 << 30) + (34'(data_i.sq) << 1);
      rem0_r <= 34'(dvd[63:32]);
      lo0_r  <= dvd[31:0];
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_st
    logic             v_in;
    m1et_pkg::flags_t fl_in;
    logic [31:0]      nn_in, lo_in, q_in;
    logic [33:0]      den_in, rem_in, rem_nxt;
    logic [34:0]      t;
    logic             ge;

    if (k == 0) begin : g_head
      always_comb begin
        v_in   = v0_r;
        fl_in  = fl0_r;
        nn_in  = nn0_r;
        lo_in  = lo0_r;
        q_in   = 32'd0;
        den_in = den0_r;
        rem_in = rem0_r;
      end
    end else begin : g_body
      always_comb begin
        v_in   = v_r[k-1];
        fl_in  = fl_r[k-1];
        nn_in  = nn_r[k-1];
        lo_in  = lo_r[k-1];
        q_in   = q_r[k-1];
        den_in = den_r[k-1];
        rem_in = rem_r[k-1];
      end
    end

    always_comb begin
      t       = {rem_in, lo_in[31]};
      ge      = t >= {1'b0, den_in};
      rem_nxt = ge ? 34'(t - {1'b0, den_in}) : t[33:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        fl_r[k]  <= fl_in;
        nn_r[k]  <= nn_in;
        lo_r[k]  <= lo_in << 1;
        den_r[k] <= den_in;
        rem_r[k] <= rem_nxt;
        q_r[k]   <= {q_in[30:0], ge};
      end
    end
  end

  always_comb begin
    c1 = (q_r[N-1] > 32'(m1et_pkg::Q30_HALF)) ? m1et_pkg::Q30_HALF : q_r[N-1][29:0];
    chi_nxt = ((34'(c1) * 34'd3) < 34'(m1et_pkg::Q30_HALF)) ? m1et_pkg::CHI_MIN : c1;
  end

  always_comb begin
    pm = flp4_r.neg ? -$signed(p4_r) : $signed(p4_r);
    priority if (flp4_r.zero) begin
      res_nxt = flp4_r.diag ? $signed(m1et_pkg::Q30_THIRD) : 32'sd0;
    end else if (flp4_r.free) begin
      res_nxt = $signed(fv4_r);
    end else begin
      res_nxt = pm + (flp4_r.diag ? $signed(32'(dsum4_r)) : 32'sd0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp1_r <= 1'b0;
      vp2_r <= 1'b0;
      vp3_r <= 1'b0;
      vp4_r <= 1'b0;
      vp5_r <= 1'b0;
    end else if (en) begin
      vp1_r <= v_r[N-1];
      vp2_r <= vp1_r;
      vp3_r <= vp2_r;
      vp4_r <= vp3_r;
      vp5_r <= vp4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flp1_r  <= fl_r[N-1];
      nnp1_r  <= nn_r[N-1];
      chi1_r  <= chi_nxt;

      flp2_r  <= flp1_r;
      nnp2_r  <= nnp1_r;
      coef2_r <= 31'(31'(chi1_r) * 31'd3) - 31'(m1et_pkg::Q30_HALF);
      dsum2_r <= m1et_pkg::Q30_HALF - chi1_r;

      flp3_r  <= flp2_r;
      nnp3_r  <= nnp2_r;
      prod3_r <= 62'(coef2_r) * 62'(nnp2_r[30:0]);
      dsum3_r <= dsum2_r;

      flp4_r  <= flp3_r;
      p4_r    <= 32'((prod3_r + 62'(m1et_pkg::Q30_HALF)) >> 30);
      fv4_r   <= flp3_r.neg ? (32'd0 - nnp3_r) : nnp3_r;
      dsum4_r <= dsum3_r;

      res5_r  <= res_nxt;
    end
  end

  assign valid_o  = vp5_r;
  assign result_o = res5_r;

endmodule
`default_nettype wire

// ----- sv/m1_eddington_tensor.sv -----
// M1-closure Eddington tensor component, Levermore chi factor.
// Input channel in_ch: row/column index, energy density and flux vector on a
// shared fixed-point scale; one request in gives one result out.
// Output channel out_ch: tensor component (i,j) as signed Q1.30.
// Throughput: one request per cycle while the skid register is empty; a full skid register drops in_ch.ready.
// Built from bit-per-stage pipelines: two ratio dividers (34 stages), the
// square root (32 stages) and the chi divider (32 stages), plus setup and
// output stages.
// Zero flux or zero energy gives one third on the diagonal and zero elsewhere;
// flux above energy gives the free-streaming product n_i*n_j.
// Reset (rst_n low, synchronous) clears every stage valid bit and the output
// and skid valid bits; data in flight is dropped.
// When out_ch.ready is low the result holds in the output register, one more
// result lands in a skid register, and only then does in_ch.ready drop and the
// whole pipeline hold; nothing is lost or repeated.
`default_nettype none
module m1_eddington_tensor (
  input wire         clk,
  input wire         rst_n,
  m1et_in_if.sink    in_ch,
  m1et_out_if.source out_ch
);

  logic               en, take;
  m1et_pkg::in_t      in_d;
  logic               fv, rv, sv, lv;
  m1et_pkg::front_t   fd;
  m1et_pkg::ratio_t   rd;
  m1et_pkg::sqrt_t    sd;
  logic signed [31:0] ld;

  logic               out_v_r, out_v_nxt, skid_v_r, skid_v_nxt;
  logic signed [31:0] out_d_r, out_d_nxt, skid_d_r, skid_d_nxt;

  assign in_d.row_index      = in_ch.row_index;
  assign in_d.col_index      = in_ch.col_index;
  assign in_d.energy_density = in_ch.energy_density;
  assign in_d.flux_x         = in_ch.flux_x;
  assign in_d.flux_y         = in_ch.flux_y;
  assign in_d.flux_z         = in_ch.flux_z;

  assign en          = !skid_v_r;
  assign in_ch.ready = en;
  assign take        = out_v_r && out_ch.ready;

  m1et_front u_front (
    .clk(clk), .rst_n(rst_n), .en(en),
    .valid_i(in_ch.valid), .data_i(in_d), .valid_o(fv), .data_o(fd)
  );

  m1et_ratio u_ratio (
    .clk(clk), .rst_n(rst_n), .en(en),
    .valid_i(fv), .data_i(fd), .valid_o(rv), .data_o(rd)
  );

  m1et_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .en(en),
    .valid_i(rv), .data_i(rd), .valid_o(sv), .data_o(sd)
  );

  m1et_chi u_chi (
    .clk(clk), .rst_n(rst_n), .en(en),
    .valid_i(sv), .data_i(sd), .valid_o(lv), .result_o(ld)
  );

  always_comb begin
    out_v_nxt  = out_v_r;
    out_d_nxt  = out_d_r;
    skid_v_nxt = skid_v_r;
    skid_d_nxt = skid_d_r;
    priority if (skid_v_r) begin
      if (take) begin
        out_d_nxt  = skid_d_r;
        skid_v_nxt = 1'b0;
      end
    end else if (lv) begin
      if (!out_v_r || take) begin
        out_v_nxt = 1'b1;
        out_d_nxt = ld;
      end else begin
        skid_v_nxt = 1'b1;
        skid_d_nxt = ld;
      end
    end else begin
      if (take) begin
        out_v_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r  <= out_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

  assign out_ch.valid            = out_v_r;
  assign out_ch.tensor_component = out_d_r;

endmodule
`default_nettype wire

// ----- sv/m1et_chk.sv -----
`default_nettype none
module m1et_chk (
  input wire        clk,
  input wire        rst_n,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire [31:0] tensor_component
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(tensor_component)))
    else $error("stalled result changed or dropped");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed(tensor_component) >= -32'sd1073741824 &&
                   $signed(tensor_component) <= 32'sd1073741824))
    else $error("result outside Q1.30 range");

  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !$past(in_ready && out_valid && out_ready)))
    else $error("input held without a waiting result");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  a_idle_in: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_ready && !out_ready) |=> !in_ready)
    else $error("input opened while output stalled and buffers full");

endmodule

bind m1_eddington_tensor m1et_chk u_chk (
  .clk(clk),
  .rst_n(rst_n),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .tensor_component(out_ch.tensor_component)
);
`default_nettype wire

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  m1et_in_if  in_ch ();
  m1et_out_if out_ch ();

  m1_eddington_tensor i_dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source));

  localparam logic [63:0] ONE_Q30  = 64'd1073741824;
  localparam logic [63:0] HALF_Q30 = 64'd536870912;
  localparam int LIMIT = 20000;

  logic [31:0] expected_q[$];
  int errors = 0;
  int idle_cycles = 0;
  bit send_gaps = 1'b1;
  bit recv_gaps = 1'b1;
  int hold_off = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    errors++;
    $display("MISMATCH %s: got %0d expected %0d", what, $signed(got), $signed(want));
  endtask

  // round(a * 2^bits / b), half up
  function automatic logic [63:0] round_ratio(input logic [63:0] a, input logic [63:0] b,
                                               input int bits);
    logic [127:0] q;
    q = ((({64'd0, a}) << (bits + 1)) / {64'd0, b});
    return 64'((q + 128'd1) >> 1);
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    r = 64'd0;
    for (int k = 31; k >= 0; k--) begin
      b = r | (64'd1 << k);
      if ({64'd0, b} * {64'd0, b} <= {64'd0, x}) r = b;
    end
    return r;
  endfunction

  function automatic logic [31:0] eddington(input m1et_pkg::in_t req);
    logic signed [63:0] fv[4];
    logic [63:0] fm[4];
    logic [63:0] f2, u2, nn, f2q, s, sq, num, den, chi, coef, prod;
    logic signed [63:0] res;
    logic neg, diag;
    fv[0] = req.flux_x; fv[1] = req.flux_y; fv[2] = req.flux_z; fv[3] = 0;
    for (int k = 0; k < 4; k++) fm[k] = fv[k] < 0 ? -fv[k] : fv[k];
    diag = req.row_index == req.col_index;
    f2 = fm[0] * fm[0] + fm[1] * fm[1] + fm[2] * fm[2];
    u2 = 64'(req.energy_density) * 64'(req.energy_density);
    if (f2 == 0 || req.energy_density == 0) return diag ? m1et_pkg::Q30_THIRD : 32'd0;
    neg = (fv[req.row_index] < 0) != (fv[req.col_index] < 0);
    nn = round_ratio(fm[req.row_index] * fm[req.col_index], f2, 30);
    if (f2 > u2) begin
      res = neg ? -$signed(nn) : $signed(nn);
      return res[31:0];
    end
    f2q = round_ratio(f2, u2, 32);
    s = (64'd4 << 32) - 3 * f2q;
    sq = int_sqrt(s << 28);
    num = (64'd3 << 31) + 2 * f2q;
    den = 5 * ONE_Q30 + 2 * sq;
    chi = ((num << 28) + (den >> 1)) / den;
    if (chi > HALF_Q30) chi = HALF_Q30;
    if (3 * chi < HALF_Q30) chi = HALF_Q30 / 3 + 1;
    coef = 3 * chi - HALF_Q30;
    prod = (coef * nn + HALF_Q30) >> 30;
    res = neg ? -$signed(prod) : $signed(prod);
    if (diag) res += $signed(HALF_Q30 - chi);
    return res[31:0];
  endfunction

  task automatic send_request(input m1et_pkg::in_t req);
    int gap;
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.row_index <= req.row_index;
    in_ch.col_index <= req.col_index;
    in_ch.energy_density <= req.energy_density;
    in_ch.flux_x <= req.flux_x;
    in_ch.flux_y <= req.flux_y;
    in_ch.flux_z <= req.flux_z;
    do @(posedge clk); while (!in_ch.ready);
    expected_q.push_back(eddington(req));
    @(negedge clk);
  endtask

  function automatic m1et_pkg::in_t make_req(input logic [1:0] r, input logic [1:0] c,
                                             input logic [31:0] u, input logic [31:0] x,
                                             input logic [31:0] y, input logic [31:0] z);
    m1et_pkg::in_t q;
    q.row_index = r; q.col_index = c; q.energy_density = u;
    q.flux_x = x; q.flux_y = y; q.flux_z = z;
    return q;
  endfunction

  function automatic logic [31:0] rand_flux(input logic [31:0] u);
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'd0;
      2: return 32'($urandom_range(0, 1000)) - 32'd500;
      default: return $urandom_range(0, 1) ? (u >> $urandom_range(1, 4)) ^ ($urandom & 32'hff)
                                            : -(u >> $urandom_range(1, 4));
    endcase
  endfunction

  function automatic m1et_pkg::in_t rand_req();
    logic [31:0] u;
    u = $urandom_range(0, 9) == 0 ? 32'($urandom_range(0, 3)) : $urandom;
    return make_req($urandom_range(0, 9) == 0 ? 2'd3 : 2'($urandom_range(0, 2)),
                    $urandom_range(0, 9) == 0 ? 2'd3 : 2'($urandom_range(0, 2)),
                    u, rand_flux(u), rand_flux(u), rand_flux(u));
  endfunction

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (expected_q.size() != 0) @(negedge clk);
  endtask

  task automatic test_directed();
    send_request(make_req(m1et_pkg::AXIS_X, m1et_pkg::AXIS_X, 32'd1000, 32'd0, 32'd0, 32'd0));
    send_request(make_req(m1et_pkg::AXIS_X, m1et_pkg::AXIS_Y, 32'd1000, 32'd0, 32'd0, 32'd0));
    send_request(make_req(m1et_pkg::AXIS_Y, m1et_pkg::AXIS_Y, 32'd0, 32'd5, 32'd7, 32'd1));
    send_request(make_req(m1et_pkg::AXIS_Z, m1et_pkg::AXIS_X, 32'd0, 32'd5, 32'd7, 32'd1));
    send_request(make_req(m1et_pkg::AXIS_X, m1et_pkg::AXIS_X, 32'd1, 32'h8000_0000,
                          32'h7fff_ffff, 32'h8000_0000));
    send_request(make_req(m1et_pkg::AXIS_X, m1et_pkg::AXIS_Y, 32'd1, 32'h8000_0000,
                          32'h7fff_ffff, 32'h8000_0000));
    send_request(make_req(m1et_pkg::AXIS_Z, m1et_pkg::AXIS_Z, 32'hffff_ffff, 32'hffff_ffff,
                          32'd0, 32'd0));
    send_request(make_req(m1et_pkg::AXIS_X, m1et_pkg::AXIS_X, 32'hffff_ffff, 32'hffff_ffff,
                          32'd0, 32'd0));
    send_request(make_req(m1et_pkg::AXIS_X, m1et_pkg::AXIS_X, 32'd100, 32'd100, 32'd0, 32'd0));
    send_request(make_req(m1et_pkg::AXIS_X, m1et_pkg::AXIS_X, 32'd100, 32'd101, 32'd0, 32'd0));
    send_request(make_req(m1et_pkg::AXIS_X, m1et_pkg::AXIS_Y, 32'd100, 32'd60, 32'hffff_ffb0,
                          32'd0));
    send_request(make_req(m1et_pkg::AXIS_Y, m1et_pkg::AXIS_Z, 32'hffff_ffff, 32'd1, 32'd1,
                          32'hffff_ffff));
    send_request(make_req(m1et_pkg::AXIS_Y, m1et_pkg::AXIS_Y, 32'hffff_ffff, 32'd1, 32'd1,
                          32'd1));
    send_request(make_req(2'd3, 2'd3, 32'd500, 32'd100, 32'd200, 32'd50));
    send_request(make_req(2'd3, m1et_pkg::AXIS_X, 32'd500, 32'd100, 32'd200, 32'd50));
    send_request(make_req(m1et_pkg::AXIS_Z, 2'd3, 32'd50, 32'd100, 32'd200, 32'd50));
    send_request(make_req(m1et_pkg::AXIS_X, m1et_pkg::AXIS_Z, 32'h7fff_ffff, 32'h7fff_ffff,
                          32'h7fff_ffff, 32'h7fff_ffff));
    send_request(make_req(m1et_pkg::AXIS_Z, m1et_pkg::AXIS_Z, 32'h5555_5555, 32'haaaa_aaaa,
                          32'h5555_5555, 32'h1234_5678));
  endtask

  task automatic test_random(input int n);
    repeat (n) send_request(rand_req());
  endtask

  task automatic test_backpressure();
    hold_off = 300;
    repeat (200) send_request(rand_req());
  endtask

  task automatic test_pause();
    wait_drained();
    test_random(20);
  endtask

  task automatic test_streaming();
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    test_random(100);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.row_index = '0; in_ch.col_index = '0; in_ch.energy_density = '0;
    in_ch.flux_x = '0; in_ch.flux_y = '0; in_ch.flux_z = '0;
    out_ch.ready = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random(200);
    test_backpressure();
    test_pause();
    test_streaming();
    wait_drained();
    repeat (150) @(negedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("m1_eddington_tensor test passed");
    end else begin
      $display("m1_eddington_tensor test failed");
    end
    $finish;
  end

  // receiver ready: random stall bursts, plus one long hold-off
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold_off) @(negedge clk);
        hold_off = 0;
        out_ch.ready <= 1'b1;
      end else if (recv_gaps && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 14);
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        report("unexpected result", out_ch.tensor_component, 32'd0);
      end else begin
        logic [31:0] want;
        want = expected_q.pop_front();
        if (out_ch.tensor_component !== want) report("tensor_component", out_ch.tensor_component,
                                                     want);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        expected_q.size() == 0 && !in_ch.valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= LIMIT) begin
        $display("m1_eddington_tensor test failed");
        $finish;
      end
    end
  end

endmodule

// ----- files.f -----
sv/m1et_pkg.sv
sv/m1et_ifs.sv
sv/m1et_front.sv
sv/m1et_ratio.sv
sv/m1et_sqrt.sv
sv/m1et_chi.sv
sv/m1_eddington_tensor.sv
sv/m1et_chk.sv
verif/tb_top.sv
